FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_SYNC(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// clocked check that also holds while reset is asserted
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`endif

FILE: rtl/pst_pkg.sv
// ---------------------------------------------------------------------------
// pst_pkg
// types and constants of the packet sequence ack tracker
// ---------------------------------------------------------------------------
package pst_pkg;

	localparam int SEQ_W     = 16;
	localparam int WIN_W     = 32;
	localparam int CNT_W     = 32;
	localparam int WIN_IDX_W = $clog2(WIN_W);

	localparam logic [SEQ_W-1:0] HALF_RANGE = SEQ_W'(32768);
	localparam logic [SEQ_W-1:0] WIN_SEQ    = SEQ_W'(WIN_W);

	typedef enum logic {
		FUNC_SEND = 1'b0,
		FUNC_RECV = 1'b1
	} func_t;

	typedef struct packed {
		func_t              func;
		logic [SEQ_W-1:0]   incoming_sequence;
	} item_word_t;

	typedef struct packed {
		logic [SEQ_W-1:0]   out_sequence;
		logic [SEQ_W-1:0]   ack_latest;
		logic [WIN_W-1:0]   ack_window;
		logic [CNT_W-1:0]   lost_estimate;
		logic [CNT_W-1:0]   sent_total;
		logic [CNT_W-1:0]   received_total;
	} result_word_t;

	typedef struct packed {
		logic               first_seen;
		logic [SEQ_W-1:0]   latest;
		logic [WIN_W-1:0]   window;
		logic [CNT_W-1:0]   lost;
	} rx_state_t;

endpackage

FILE: rtl/pst_rx_update.sv
// ---------------------------------------------------------------------------
// pst_rx_update
// next receive-side state for one incoming sequence number
// ---------------------------------------------------------------------------
module pst_rx_update import pst_pkg::*; (
	input  rx_state_t           cur,
	input  logic [SEQ_W-1:0]    seq,
	output rx_state_t           nxt
);

	logic [SEQ_W-1:0]   delta;
	logic [SEQ_W-1:0]   delta_m1;
	logic [SEQ_W-1:0]   behind;
	logic [SEQ_W-1:0]   behind_m1;
	logic               newer;
	logic [CNT_W:0]     lost_sum;
	logic [CNT_W-1:0]   lost_add;
	logic [WIN_W-1:0]   shifted;
	logic [WIN_W-1:0]   new_bit;
	logic [WIN_W-1:0]   old_bit;
	logic               old_in_win;

	assign delta      = seq - cur.latest;
	assign delta_m1   = delta - SEQ_W'(1);
	assign behind     = SEQ_W'(0) - delta;
	assign behind_m1  = behind - SEQ_W'(1);
	assign newer      = !delta[SEQ_W-1] || (delta == HALF_RANGE);
	assign lost_sum   = {1'b0, cur.lost} + (CNT_W+1)'(delta_m1);
	assign lost_add   = lost_sum[CNT_W] ? {CNT_W{1'b1}} : lost_sum[CNT_W-1:0];
	assign shifted    = (delta >= WIN_SEQ) ? '0 : (cur.window << delta[WIN_IDX_W-1:0]);
	assign new_bit    = (delta <= WIN_SEQ) ? (WIN_W'(1) << delta_m1[WIN_IDX_W-1:0]) : '0;
	assign old_in_win = (behind <= WIN_SEQ);
	assign old_bit    = WIN_W'(1) << behind_m1[WIN_IDX_W-1:0];

	always_comb begin
		nxt = cur;
		if (!cur.first_seen) begin
			nxt.first_seen = 1'b1;
			nxt.latest     = seq;
			nxt.window     = '0;
		end else if (delta == '0) begin
			nxt = cur;
		end else if (newer) begin
			nxt.lost   = lost_add;
			nxt.window = shifted | new_bit;
			nxt.latest = seq;
		end else if (old_in_win) begin
			if (((cur.window & old_bit) == '0) && (cur.lost != '0)) begin
				nxt.lost = cur.lost - CNT_W'(1);
			end
			nxt.window = cur.window | old_bit;
		end
	end

endmodule

FILE: rtl/packet_sequence_ack_tracker.sv
// ---------------------------------------------------------------------------
// packet_sequence_ack_tracker
// pipeline: item registered in the input stage, then result in the result stage
// throughput: one item per cycle unless the result stalls; combinational update
// reset: arst_n clears all tracker state and the valid bits of both pipeline stages
// ---------------------------------------------------------------------------
module packet_sequence_ack_tracker import pst_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  item_word_t     item,
	output logic           result_valid,
	input  logic           result_ready,
	output result_word_t   result
);

	logic               stall;
	logic               valid_s1;
	item_word_t         item_s1;
	logic               valid_s2;
	result_word_t       result_s2;
	logic               step;
	logic               is_recv;

	logic [SEQ_W-1:0]   next_out_seq_q;
	logic [CNT_W-1:0]   sent_q;
	logic [CNT_W-1:0]   recv_q;
	rx_state_t          rx_q;
	rx_state_t          rx_upd;
	rx_state_t          rx_nxt;
	result_word_t       res_nxt;

	assign stall      = valid_s2 && !result_ready;
	assign item_ready = !stall;
	assign step       = valid_s1 && !stall;
	assign is_recv    = (item_s1.func == FUNC_RECV);

	pst_rx_update u_rx_update (
		.cur (rx_q),
		.seq (item_s1.incoming_sequence),
		.nxt (rx_upd)
	);

	assign rx_nxt = is_recv ? rx_upd : rx_q;

	always_comb begin
		res_nxt.out_sequence   = is_recv ? '0 : next_out_seq_q;
		res_nxt.ack_latest     = rx_nxt.latest;
		res_nxt.ack_window     = rx_nxt.window;
		res_nxt.lost_estimate  = rx_nxt.lost;
		res_nxt.sent_total     = is_recv ? sent_q : sent_q + CNT_W'(1);
		res_nxt.received_total = is_recv ? recv_q + CNT_W'(1) : recv_q;
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			item_s1 <= item;
		end
	end

	// tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_out_seq_q <= '0;
			sent_q         <= '0;
			recv_q         <= '0;
			rx_q           <= '0;
		end else if (step) begin
			rx_q <= rx_nxt;
			if (is_recv) begin
				recv_q <= res_nxt.received_total;
			end else begin
				next_out_seq_q <= next_out_seq_q + SEQ_W'(1);
				sent_q         <= res_nxt.sent_total;
			end
		end
	end

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= res_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

FILE: rtl/pst_checker.sv
// ---------------------------------------------------------------------------
// pst_checker
// port-level checks of the packet sequence ack tracker
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pst_checker import pst_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           item_ready,
	input  logic           result_valid,
	input  logic           result_ready,
	input  result_word_t   result
);

	logic take;
	logic item_take;

	assign take      = result_valid && result_ready;
	assign item_take = item_valid && item_ready;

	// between back-to-back results exactly one of the totals steps
	property p_one_total;
		(take ##1 take) |->
			(((result.sent_total - $past(result.sent_total)) == CNT_W'(1)) !=
			((result.received_total - $past(result.received_total)) == CNT_W'(1)));
	endproperty

	// a send leaves the receive side untouched
	property p_send_keeps_rx;
		(take ##1 (take && (result.received_total == $past(result.received_total)))) |->
			($stable(result.ack_latest) && $stable(result.ack_window) &&
			$stable(result.lost_estimate));
	endproperty

	// result word holds while stalled
	`ASSERT_SYNC(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result))

	// no result word during reset
	`ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !result_valid)

	`ASSERT_SYNC(a_one_total, p_one_total)

	`ASSERT_SYNC(a_send_keeps_rx, p_send_keeps_rx)

	// a word offered while ready is low stays offered
	`ASSERT_SYNC(a_item_wait, item_valid && !item_ready && !item_take |=> item_valid)

endmodule

bind packet_sequence_ack_tracker pst_checker u_pst_checker (.*);
